>>> design/nrth_pkg.sv
// ----------------------------------------------------------------------------
// nrth_pkg
// Shared types, widths, micro-op table and codes for the nearest ray/triangle
// hit block.
// ----------------------------------------------------------------------------
package nrth_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CRD_W     = 32;              // coordinate width
  localparam int TQ_W      = FRAC_BITS + 1;   // t in Q1.F
  localparam int IDX_W     = 16;
  localparam int ACC_W     = 144;             // exact edge dot products need 137 bits
  localparam int BOP_W     = 72;              // multiplier digit-serial operand
  localparam int DIG_W     = 8;
  localparam int MUL_STEPS = BOP_W / DIG_W;
  localparam int NRM_W     = 67;              // normal components
  localparam int DEN_W     = 104;             // normal dot direction / origin
  localparam int PNT_W     = 34;              // hit point before saturation
  localparam int CRS_W     = 69;              // edge cross product components
  localparam int PC_W      = 5;
  localparam int CNT_W     = 5;
  localparam int CFG_IDX_W = 4;

  localparam logic [PC_W-1:0] PC_NUM_END    = PC_W'(11);
  localparam logic [PC_W-1:0] PC_EDGE_FIRST = PC_W'(15);
  localparam logic [PC_W-1:0] PC_EDGE_LAST  = PC_W'(23);
  localparam logic [1:0]      EDGE_LAST     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_T     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PAR_THR   = 4'd7;

  localparam logic [1:0] CX = 2'd0;
  localparam logic [1:0] CY = 2'd1;
  localparam logic [1:0] CZ = 2'd2;

  typedef struct packed {
    logic signed [CRD_W-1:0] a_x;
    logic signed [CRD_W-1:0] a_y;
    logic signed [CRD_W-1:0] a_z;
    logic signed [CRD_W-1:0] b_x;
    logic signed [CRD_W-1:0] b_y;
    logic signed [CRD_W-1:0] b_z;
    logic signed [CRD_W-1:0] c_x;
    logic signed [CRD_W-1:0] c_y;
    logic signed [CRD_W-1:0] c_z;
    logic                    last_face;
  } in_item_t;

  typedef struct packed {
    logic                    found;
    logic [IDX_W-1:0]        face_index;
    logic [TQ_W-1:0]         hit_distance;
    logic signed [CRD_W-1:0] hit_x;
    logic signed [CRD_W-1:0] hit_y;
    logic signed [CRD_W-1:0] hit_z;
  } out_item_t;

  typedef enum logic [1:0] {ASRC_E1, ASRC_N, ASRC_DIR, ASRC_EDGE} asrc_e;
  typedef enum logic [2:0] {BSRC_E2, BSRC_DIR, BSRC_OW, BSRC_TQ, BSRC_D, BSRC_C} bsrc_e;
  typedef enum logic [2:0] {DST_NONE, DST_N, DST_DEN, DST_NUM, DST_P, DST_C, DST_EDGE} dst_e;

  typedef struct packed {
    asrc_e      asrc;
    logic [1:0] acomp;
    bsrc_e      bsrc;
    logic [1:0] bcomp;
    logic       clr;
    logic       sub;
    dst_e       dst;
    logic [1:0] dcomp;
  } uop_t;

  typedef struct packed {
    logic       capture;
    logic       mac_load;
    logic       mac_step;
    logic       mac_last;
    logic       mac_wb;
    uop_t       uop;
    logic [1:0] edge_sel;
    logic       chk;
    logic       div_step;
    logic       div_first;
    logic       update;
    logic       hit;
  } cmd_t;

  typedef struct packed {
    logic acc_neg;
    logic geom_ok;
    logic tq_ok;
    logic last;
  } status_t;

  function automatic uop_t mk(asrc_e a, logic [1:0] ac, bsrc_e b, logic [1:0] bc,
                              logic clr, logic sub, dst_e d, logic [1:0] dc);
    uop_t u;
    u.asrc  = a;
    u.acomp = ac;
    u.bsrc  = b;
    u.bcomp = bc;
    u.clr   = clr;
    u.sub   = sub;
    u.dst   = d;
    u.dcomp = dc;
    return u;
  endfunction

  // one product per entry; the edge block (15..23) is replayed per edge
  function automatic uop_t uop_at(logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      5'd0:    u = mk(ASRC_E1, CY, BSRC_E2, CZ, 1'b1, 1'b0, DST_NONE, CX);
      5'd1:    u = mk(ASRC_E1, CZ, BSRC_E2, CY, 1'b0, 1'b1, DST_N,    CX);
      5'd2:    u = mk(ASRC_E1, CZ, BSRC_E2, CX, 1'b1, 1'b0, DST_NONE, CX);
      5'd3:    u = mk(ASRC_E1, CX, BSRC_E2, CZ, 1'b0, 1'b1, DST_N,    CY);
      5'd4:    u = mk(ASRC_E1, CX, BSRC_E2, CY, 1'b1, 1'b0, DST_NONE, CX);
      5'd5:    u = mk(ASRC_E1, CY, BSRC_E2, CX, 1'b0, 1'b1, DST_N,    CZ);
      5'd6:    u = mk(ASRC_N,  CX, BSRC_DIR, CX, 1'b1, 1'b0, DST_NONE, CX);
      5'd7:    u = mk(ASRC_N,  CY, BSRC_DIR, CY, 1'b0, 1'b0, DST_NONE, CX);
      5'd8:    u = mk(ASRC_N,  CZ, BSRC_DIR, CZ, 1'b0, 1'b0, DST_DEN,  CX);
      5'd9:    u = mk(ASRC_N,  CX, BSRC_OW, CX, 1'b1, 1'b0, DST_NONE, CX);
      5'd10:   u = mk(ASRC_N,  CY, BSRC_OW, CY, 1'b0, 1'b0, DST_NONE, CX);
      5'd11:   u = mk(ASRC_N,  CZ, BSRC_OW, CZ, 1'b0, 1'b0, DST_NUM,  CX);
      5'd12:   u = mk(ASRC_DIR, CX, BSRC_TQ, CX, 1'b1, 1'b0, DST_P,   CX);
      5'd13:   u = mk(ASRC_DIR, CY, BSRC_TQ, CX, 1'b1, 1'b0, DST_P,   CY);
      5'd14:   u = mk(ASRC_DIR, CZ, BSRC_TQ, CX, 1'b1, 1'b0, DST_P,   CZ);
      5'd15:   u = mk(ASRC_EDGE, CY, BSRC_D, CZ, 1'b1, 1'b0, DST_NONE, CX);
      5'd16:   u = mk(ASRC_EDGE, CZ, BSRC_D, CY, 1'b0, 1'b1, DST_C,    CX);
      5'd17:   u = mk(ASRC_EDGE, CZ, BSRC_D, CX, 1'b1, 1'b0, DST_NONE, CX);
      5'd18:   u = mk(ASRC_EDGE, CX, BSRC_D, CZ, 1'b0, 1'b1, DST_C,    CY);
      5'd19:   u = mk(ASRC_EDGE, CX, BSRC_D, CY, 1'b1, 1'b0, DST_NONE, CX);
      5'd20:   u = mk(ASRC_EDGE, CY, BSRC_D, CX, 1'b0, 1'b1, DST_C,    CZ);
      5'd21:   u = mk(ASRC_N,  CX, BSRC_C, CX, 1'b1, 1'b0, DST_NONE, CX);
      5'd22:   u = mk(ASRC_N,  CY, BSRC_C, CY, 1'b0, 1'b0, DST_NONE, CX);
      5'd23:   u = mk(ASRC_N,  CZ, BSRC_C, CZ, 1'b0, 1'b0, DST_EDGE, CX);
      default: u = mk(ASRC_E1, CX, BSRC_E2, CX, 1'b1, 1'b0, DST_NONE, CX);
    endcase
    return u;
  endfunction

endpackage

>>> design/nearest_ray_triangle_hit.sv
// ----------------------------------------------------------------------------
// nearest_ray_triangle_hit
// Nearest hit of a configured ray segment over a stream of triangles.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  in       | in_valid_i / in_stall_o| in_data_i  : three vertices, last flag
//  out      | out_valid_o/out_stall_i| out_data_o : found, index, t, point
//  cfg      | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  a triangle that reaches the last edge test runs 42 products on one
//  144x9-bit digit-serial multiply-accumulate unit (each one loaded, stepped
//  digit by digit and written back), 17 divider steps and the control states
//  a rejected triangle leaves early, as soon as a test fails: the plane test,
//  the t range check or one of the edge tests
//  reset clears the search and loads the register defaults; no clearing pass
//  the input stalls while a triangle is in work; the last triangle of a mesh
//  waits at its end while the previous result has not been transferred
module nearest_ray_triangle_hit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  nrth_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output nrth_pkg::out_item_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nrth_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import nrth_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready_o = 1'b1;

  nrth_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nrth_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

>>> design/nrth_ctrl.sv
// ----------------------------------------------------------------------------
// nrth_ctrl
// Sequencer: steps the micro-op table through the shared multiplier, runs the
// divider and decides hit or miss for each triangle.
// ----------------------------------------------------------------------------
module nrth_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  nrth_pkg::status_t sts_i,
  output nrth_pkg::cmd_t   cmd_o
);
  import nrth_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL, S_WB, S_CHECK, S_DIV, S_TQ, S_DONE
  } state_e;

  state_e           state_q;
  logic [PC_W-1:0]  pc_q;
  logic [1:0]       edge_q;
  logic [CNT_W-1:0] cnt_q;
  logic             hit_q;
  logic             out_valid_q;
  uop_t             uop;
  logic             done_go;

  assign uop        = uop_at(pc_q);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  // a finished mesh waits only while the previous result is still held
  assign done_go    = !(sts_i.last && out_valid_q);

  always_comb begin
    cmd_o           = '0;
    cmd_o.uop       = uop;
    cmd_o.edge_sel  = edge_q;
    cmd_o.hit       = hit_q;
    cmd_o.capture   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mac_load  = (state_q == S_LOAD);
    cmd_o.mac_step  = (state_q == S_MUL);
    cmd_o.mac_last  = (cnt_q == CNT_W'(MUL_STEPS - 1));
    cmd_o.mac_wb    = (state_q == S_WB);
    cmd_o.chk       = (state_q == S_CHECK);
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.div_first = (cnt_q == '0);
    cmd_o.update    = (state_q == S_DONE) && done_go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      edge_q      <= '0;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            pc_q    <= '0;
            edge_q  <= '0;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt_q   <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
            state_q <= S_WB;
          end
        end
        S_WB: begin
          if (uop.dst == DST_EDGE && sts_i.acc_neg) begin
            hit_q   <= 1'b0;
            state_q <= S_DONE;
          end else if (pc_q == PC_NUM_END) begin
            state_q <= S_CHECK;
          end else if (pc_q == PC_EDGE_LAST) begin
            if (edge_q == EDGE_LAST) begin
              hit_q   <= 1'b1;
              state_q <= S_DONE;
            end else begin
              edge_q  <= edge_q + 1'b1;
              pc_q    <= PC_EDGE_FIRST;
              state_q <= S_LOAD;
            end
          end else begin
            pc_q    <= pc_q + 1'b1;
            state_q <= S_LOAD;
          end
        end
        S_CHECK: begin
          cnt_q <= '0;
          if (sts_i.geom_ok) begin
            state_q <= S_DIV;
          end else begin
            hit_q   <= 1'b0;
            state_q <= S_DONE;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(TQ_W - 1)) begin
            state_q <= S_TQ;
          end
        end
        S_TQ: begin
          if (sts_i.tq_ok) begin
            pc_q    <= pc_q + 1'b1;
            state_q <= S_LOAD;
          end else begin
            hit_q   <= 1'b0;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_go) begin
            if (sts_i.last) begin
              out_valid_q <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/nrth_dp.sv
// ----------------------------------------------------------------------------
// nrth_dp
// Datapath: configuration registers, triangle register, digit-serial
// multiply-accumulate unit, restoring divider and nearest-hit tracking.
// ----------------------------------------------------------------------------
module nrth_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [nrth_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  input  nrth_pkg::in_item_t                 in_data_i,
  output nrth_pkg::out_item_t                out_data_o,
  input  nrth_pkg::cmd_t                     cmd_i,
  output nrth_pkg::status_t                  sts_o
);
  import nrth_pkg::*;

  // configuration
  logic signed [CRD_W-1:0] org_q [3];
  logic signed [CRD_W-1:0] dir_q [3];
  logic [TQ_W-1:0]         min_t_q;
  logic [31:0]             thr_q;

  in_item_t                tri_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] a_sh_q;
  logic [BOP_W-1:0]        b_sh_q;
  logic                    sub_q;
  logic signed [NRM_W-1:0] n_q [3];
  logic signed [DEN_W-1:0] den_q;
  logic signed [DEN_W-1:0] num_q;
  logic signed [PNT_W-1:0] p_q [3];
  logic signed [CRS_W-1:0] c_q [3];
  logic [DEN_W-1:0]        abs_q;
  logic [DEN_W-1:0]        rem_q;
  logic [TQ_W-1:0]         tq_q;

  logic [IDX_W-1:0]        face_cnt_q;
  logic                    best_found_q;
  logic [IDX_W-1:0]        best_index_q;
  logic [TQ_W-1:0]         best_dist_q;
  logic signed [CRD_W-1:0] best_pt_q [3];
  out_item_t               out_q;

  logic signed [CRD_W-1:0] va [3];
  logic signed [CRD_W-1:0] vb [3];
  logic signed [CRD_W-1:0] vc [3];
  logic signed [CRD_W-1:0] v0 [3];
  logic signed [CRD_W-1:0] v1 [3];
  logic signed [CRD_W:0]   e1_w [3];
  logic signed [CRD_W:0]   e2_w [3];
  logic signed [CRD_W:0]   ow_w [3];
  logic signed [CRD_W:0]   eg_w [3];
  logic signed [PNT_W:0]   d_w [3];
  logic signed [CRD_W-1:0] sat_w [3];
  logic signed [ACC_W-1:0] a_op;
  logic signed [BOP_W-1:0] b_op;
  logic signed [DIG_W:0]   dig;
  logic signed [ACC_W+DIG_W:0] prod;
  logic signed [ACC_W-1:0] acc_shr;
  logic signed [DEN_W-1:0] numr;
  logic [DEN_W-1:0]        absden;
  logic [DEN_W-1:0]        remsh;
  logic                    ge;
  logic                    better;

  assign va = '{tri_q.a_x, tri_q.a_y, tri_q.a_z};
  assign vb = '{tri_q.b_x, tri_q.b_y, tri_q.b_z};
  assign vc = '{tri_q.c_x, tri_q.c_y, tri_q.c_z};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (cmd_i.edge_sel)
        2'd1:    begin v0[k] = vb[k]; v1[k] = vc[k]; end
        2'd2:    begin v0[k] = vc[k]; v1[k] = va[k]; end
        default: begin v0[k] = va[k]; v1[k] = vb[k]; end
      endcase
      e1_w[k] = (CRD_W+1)'(vb[k]) - (CRD_W+1)'(va[k]);
      e2_w[k] = (CRD_W+1)'(vc[k]) - (CRD_W+1)'(va[k]);
      ow_w[k] = (CRD_W+1)'(org_q[k]) - (CRD_W+1)'(va[k]);
      eg_w[k] = (CRD_W+1)'(v1[k]) - (CRD_W+1)'(v0[k]);
      d_w[k]  = (PNT_W+1)'(p_q[k]) - (PNT_W+1)'(v0[k]);
      if (!p_q[k][PNT_W-1] && p_q[k][PNT_W-2:CRD_W-1] != '0) begin
        sat_w[k] = {1'b0, {(CRD_W-1){1'b1}}};
      end else if (p_q[k][PNT_W-1] && p_q[k][PNT_W-2:CRD_W-1] != '1) begin
        sat_w[k] = {1'b1, {(CRD_W-1){1'b0}}};
      end else begin
        sat_w[k] = p_q[k][CRD_W-1:0];
      end
    end
  end

  // operand selection
  always_comb begin
    unique case (cmd_i.uop.asrc)
      ASRC_E1:   a_op = ACC_W'(e1_w[cmd_i.uop.acomp]);
      ASRC_N:    a_op = ACC_W'(n_q[cmd_i.uop.acomp]);
      ASRC_DIR:  a_op = ACC_W'(dir_q[cmd_i.uop.acomp]);
      ASRC_EDGE: a_op = ACC_W'(eg_w[cmd_i.uop.acomp]);
      default:   a_op = '0;
    endcase
    unique case (cmd_i.uop.bsrc)
      BSRC_E2:  b_op = BOP_W'(e2_w[cmd_i.uop.bcomp]);
      BSRC_DIR: b_op = BOP_W'(dir_q[cmd_i.uop.bcomp]);
      BSRC_OW:  b_op = BOP_W'(ow_w[cmd_i.uop.bcomp]);
      BSRC_TQ:  b_op = BOP_W'($signed({1'b0, tq_q}));
      BSRC_D:   b_op = BOP_W'(d_w[cmd_i.uop.bcomp]);
      BSRC_C:   b_op = BOP_W'(c_q[cmd_i.uop.bcomp]);
      default:  b_op = '0;
    endcase
  end

  // low digits unsigned, top digit carries the sign
  assign dig     = $signed({cmd_i.mac_last & b_sh_q[DIG_W-1], b_sh_q[DIG_W-1:0]});
  assign prod    = a_sh_q * dig;
  assign acc_shr = acc_q >>> FRAC_BITS;

  // intersection test on the stored denominator and numerator, and divider compare
  always_comb begin
    absden = den_q[DEN_W-1] ? DEN_W'(-den_q) : DEN_W'(den_q);
    numr   = den_q[DEN_W-1] ? num_q : -num_q;
    remsh  = cmd_i.div_first ? rem_q : {rem_q[DEN_W-2:0], 1'b0};
    ge     = (remsh >= abs_q);
  end

  assign sts_o.acc_neg = acc_q[ACC_W-1];
  assign sts_o.geom_ok = (den_q != '0) && (absden >= DEN_W'(thr_q)) &&
                         !numr[DEN_W-1] && (DEN_W'(numr) <= absden);
  assign sts_o.tq_ok   = (tq_q >= min_t_q);
  assign sts_o.last    = tri_q.last_face;

  assign better     = cmd_i.hit && (!best_found_q || tq_q < best_dist_q);
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        org_q[k]     <= '0;
        dir_q[k]     <= '0;
        best_pt_q[k] <= '0;
      end
      min_t_q      <= TQ_W'(1);
      thr_q        <= 32'd1;
      face_cnt_q   <= '0;
      best_found_q <= 1'b0;
      best_index_q <= '0;
      best_dist_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_ORIGIN_X: org_q[0] <= cfg_data_i;
          CFG_ORIGIN_Y: org_q[1] <= cfg_data_i;
          CFG_ORIGIN_Z: org_q[2] <= cfg_data_i;
          CFG_DIR_X:    dir_q[0] <= cfg_data_i;
          CFG_DIR_Y:    dir_q[1] <= cfg_data_i;
          CFG_DIR_Z:    dir_q[2] <= cfg_data_i;
          CFG_MIN_T:    min_t_q  <= cfg_data_i[TQ_W-1:0];
          CFG_PAR_THR:  thr_q    <= cfg_data_i;
          default:      ;
        endcase
      end
      if (cmd_i.update) begin
        if (tri_q.last_face) begin
          face_cnt_q   <= '0;
          best_found_q <= 1'b0;
          best_index_q <= '0;
          best_dist_q  <= '0;
          for (int k = 0; k < 3; k++) begin
            best_pt_q[k] <= '0;
          end
        end else begin
          face_cnt_q <= face_cnt_q + 1'b1;
          if (better) begin
            best_found_q <= 1'b1;
            best_index_q <= face_cnt_q;
            best_dist_q  <= tq_q;
            for (int k = 0; k < 3; k++) begin
              best_pt_q[k] <= sat_w[k];
            end
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tri_q <= in_data_i;
    end
    if (cmd_i.mac_load) begin
      a_sh_q <= a_op;
      b_sh_q <= b_op;
      sub_q  <= cmd_i.uop.sub;
      if (cmd_i.uop.clr) begin
        acc_q <= '0;
      end
    end
    if (cmd_i.mac_step) begin
      acc_q  <= sub_q ? acc_q - prod[ACC_W-1:0] : acc_q + prod[ACC_W-1:0];
      a_sh_q <= a_sh_q <<< DIG_W;
      b_sh_q <= b_sh_q >> DIG_W;
    end
    if (cmd_i.mac_wb) begin
      unique case (cmd_i.uop.dst)
        DST_N:   n_q[cmd_i.uop.dcomp] <= acc_q[NRM_W-1:0];
        DST_DEN: den_q <= acc_q[DEN_W-1:0];
        DST_NUM: num_q <= acc_q[DEN_W-1:0];
        DST_P:   p_q[cmd_i.uop.dcomp] <= PNT_W'(org_q[cmd_i.uop.dcomp]) +
                                         $signed(acc_shr[PNT_W-1:0]);
        DST_C:   c_q[cmd_i.uop.dcomp] <= acc_q[CRS_W-1:0];
        default: ;
      endcase
    end
    if (cmd_i.chk) begin
      abs_q <= absden;
      rem_q <= DEN_W'(numr);
      tq_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? remsh - abs_q : remsh;
      tq_q  <= {tq_q[TQ_W-2:0], ge};
    end
    if (cmd_i.update && tri_q.last_face) begin
      if (better || best_found_q) begin
        out_q.found        <= 1'b1;
        out_q.face_index   <= better ? face_cnt_q : best_index_q;
        out_q.hit_distance <= better ? tq_q : best_dist_q;
        out_q.hit_x        <= better ? sat_w[0] : best_pt_q[0];
        out_q.hit_y        <= better ? sat_w[1] : best_pt_q[1];
        out_q.hit_z        <= better ? sat_w[2] : best_pt_q[2];
      end else begin
        out_q <= '0;
      end
    end
  end

endmodule
